@@ rtl/core/global_alignment_score_top_assert.svh @@
// Assertion macros shared by the checker of the alignment score block.
// Depends on nothing; included by the checker file.
`ifndef GLOBAL_ALIGNMENT_SCORE_TOP_ASSERT_SVH
`define GLOBAL_ALIGNMENT_SCORE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GAS_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gas_pkg.sv @@
// Shared types and constants of the global alignment score block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package gas_pkg;

    localparam int QUERY_MAX     = 256;
    localparam int REFERENCE_MAX = 65535;

    localparam int QCNT_W  = $clog2(QUERY_MAX + 1);
    localparam int RCNT_W  = $clog2(REFERENCE_MAX + 1);
    localparam int SCORE_W = $clog2(2 * (QUERY_MAX + REFERENCE_MAX)) + 1;
    localparam int SYM_W   = 8;

    typedef logic signed [SCORE_W-1:0] t_score;
    typedef logic [SYM_W-1:0]          t_sym;

    localparam t_score SCORE_MATCH    = t_score'(1);
    localparam t_score SCORE_MISMATCH = t_score'(-1);
    localparam t_score SCORE_GAP      = t_score'(-2);

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_REF    = 2'd1,
        MODE_FINISH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_REF    = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    // One token travelling down the cell chain.
    typedef struct packed {
        logic   valid;
        t_kind  kind;
        t_sym   sym;
        t_score val_a;   // load value, new score of the upper cell, or carried result
        t_score val_b;   // old score of the upper cell (diagonal source)
        logic   ovf;
    } t_token;

endpackage

`default_nettype wire

@@ rtl/core/global_alignment_score_top.sv @@
// Top level of the global alignment score block (linear gap scoring).
// Depends on gas_pkg, gas_feed and gas_cell.
//
// Usage: while o_stall is low the input channel takes one beat per cycle.
// Mode 0 loads a query symbol, mode 1 streams a reference symbol, mode 2
// finishes the pair and produces one result beat (score and overflow flag),
// and mode 3 is ignored. Query symbols must come before the reference of a pair;
// late or excess symbols are dropped and reported through the overflow flag of the result.
// Throughput is one input beat per cycle in every mode while the chain is not
// stalled: each beat becomes a token that walks down a chain of QUERY_MAX
// cells, one cell per cycle unless stalled, so the cells work on several
// reference symbols at once as a wavefront. A finish beat reaches o_valid
// through the first cell register, which loads at its accepting edge, then
// the remaining 255 cell registers and the output register; a stall freezes it.
// Reset clears the counters, the first score entry and the cell occupancy
// flags; query symbols are not cleared and are rewritten when loaded.
// When the receiver holds i_stall while a result waits, the whole chain
// freezes and o_stall is raised toward the sender until the beat is taken.
`default_nettype none

module global_alignment_score_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire [1:0]                         i_mode,
    input  wire [7:0]                         i_symbol,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic signed [gas_pkg::SCORE_W-1:0] o_score,
    output logic                              o_overflow
);

    gas_pkg::t_token w_tok [0:gas_pkg::QUERY_MAX];
    logic            w_adv;
    logic            w_accept;
    logic            w_tail_fin;

    logic            r_out_valid;
    gas_pkg::t_score r_score;
    logic            r_ovf;

    // The chain moves unless a finished result is held by the receiver.
    assign w_adv    = !(r_out_valid && i_stall);
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    gas_feed u_feed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (i_mode),
        .i_symbol (i_symbol),
        .o_tok    (w_tok[0])
    );

    // Cell k holds query row k+1 of the score column.
    for (genvar k = 0; k < gas_pkg::QUERY_MAX; k++) begin : g_cell
        gas_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // Only finish tokens leave the chain as results; reference tokens drop off.
    assign w_tail_fin = w_tok[gas_pkg::QUERY_MAX].valid &&
                        (w_tok[gas_pkg::QUERY_MAX].kind == gas_pkg::KIND_FINISH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tail_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_tail_fin) begin
            r_score <= w_tok[gas_pkg::QUERY_MAX].val_a;
            r_ovf   <= w_tok[gas_pkg::QUERY_MAX].ovf;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_score    = r_score;
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

@@ rtl/core/gas_cell.sv @@
// One cell of the systolic chain: holds one query symbol and one score entry.
// Depends on gas_pkg.
`default_nettype none

module gas_cell (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_adv,
    input  gas_pkg::t_token i_tok,
    output gas_pkg::t_token o_tok
);

    gas_pkg::t_token r_tok, n_tok;
    logic            r_active, n_active;
    gas_pkg::t_sym   r_sym, n_sym;
    gas_pkg::t_score r_val, n_val;

    gas_pkg::t_score w_pair, w_diag, w_up, w_left, w_best0, w_best;

    always_comb begin
        w_pair  = (i_tok.sym == r_sym) ? gas_pkg::SCORE_MATCH : gas_pkg::SCORE_MISMATCH;
        w_diag  = i_tok.val_b + w_pair;
        w_up    = i_tok.val_a + gas_pkg::SCORE_GAP;
        w_left  = r_val + gas_pkg::SCORE_GAP;
        w_best0 = (w_up > w_diag) ? w_up : w_diag;
        w_best  = (w_left > w_best0) ? w_left : w_best0;
    end

    always_comb begin
        n_tok    = i_tok;
        n_active = r_active;
        n_sym    = r_sym;
        n_val    = r_val;
        if (i_tok.valid) begin
            case (i_tok.kind)
                gas_pkg::KIND_LOAD: begin
                    // The first free cell takes the symbol and absorbs the beat.
                    if (!r_active) begin
                        n_active    = 1'b1;
                        n_sym       = i_tok.sym;
                        n_val       = i_tok.val_a;
                        n_tok.valid = 1'b0;
                    end
                end
                gas_pkg::KIND_REF: begin
                    if (r_active) begin
                        n_val       = w_best;
                        n_tok.val_a = w_best;
                        n_tok.val_b = r_val;
                    end
                end
                gas_pkg::KIND_FINISH: begin
                    if (r_active) begin
                        n_tok.val_a = r_val;
                        n_active    = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_active <= 1'b0;
        end else if (i_adv) begin
            r_tok    <= n_tok;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sym <= n_sym;
            r_val <= n_val;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

@@ rtl/core/gas_feed.sv @@
// Input decoder of the alignment block: sequence counters, first score row
// entry and overflow flag; turns accepted beats into chain tokens. Uses gas_pkg.
`default_nettype none

module gas_feed (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire [1:0]            i_mode,
    input  wire [7:0]            i_symbol,
    output gas_pkg::t_token      o_tok
);

    logic [gas_pkg::QCNT_W-1:0] r_qcount, n_qcount;
    logic [gas_pkg::RCNT_W-1:0] r_rcount, n_rcount;
    gas_pkg::t_score            r_qgap, n_qgap;   // -2 times the query length
    gas_pkg::t_score            r_col0, n_col0;   // -2 times the reference length
    logic                       r_ovf, n_ovf;

    always_comb begin
        n_qcount = r_qcount;
        n_rcount = r_rcount;
        n_qgap   = r_qgap;
        n_col0   = r_col0;
        n_ovf    = r_ovf;
        o_tok       = '0;
        o_tok.sym   = i_symbol;
        if (i_accept) begin
            case (i_mode)
                gas_pkg::MODE_LOAD: begin
                    if ((r_rcount != '0) ||
                        (r_qcount == gas_pkg::QCNT_W'(gas_pkg::QUERY_MAX))) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_qcount    = r_qcount + gas_pkg::QCNT_W'(1);
                        n_qgap      = r_qgap + gas_pkg::SCORE_GAP;
                        o_tok.valid = 1'b1;
                        o_tok.kind  = gas_pkg::KIND_LOAD;
                        o_tok.val_a = r_qgap + gas_pkg::SCORE_GAP;
                    end
                end
                gas_pkg::MODE_REF: begin
                    if (r_rcount == gas_pkg::RCNT_W'(gas_pkg::REFERENCE_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_rcount    = r_rcount + gas_pkg::RCNT_W'(1);
                        n_col0      = r_col0 + gas_pkg::SCORE_GAP;
                        o_tok.valid = 1'b1;
                        o_tok.kind  = gas_pkg::KIND_REF;
                        o_tok.val_a = r_col0 + gas_pkg::SCORE_GAP;
                        o_tok.val_b = r_col0;
                    end
                end
                gas_pkg::MODE_FINISH: begin
                    o_tok.valid = 1'b1;
                    o_tok.kind  = gas_pkg::KIND_FINISH;
                    o_tok.val_a = r_col0;
                    o_tok.ovf   = r_ovf;
                    n_qcount    = '0;
                    n_rcount    = '0;
                    n_qgap      = '0;
                    n_col0      = '0;
                    n_ovf       = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcount <= '0;
            r_rcount <= '0;
            r_qgap   <= '0;
            r_col0   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_qcount <= n_qcount;
            r_rcount <= n_rcount;
            r_qgap   <= n_qgap;
            r_col0   <= n_col0;
            r_ovf    <= n_ovf;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/gas_checker.sv @@
// Port-level checker for the global alignment score block, bound to its top.
// Depends on gas_pkg and global_alignment_score_top_assert.svh.
`default_nettype none

`include "global_alignment_score_top_assert.svh"

module gas_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_stall,
    input wire                               o_valid,
    input wire                               i_stall,
    input wire signed [gas_pkg::SCORE_W-1:0] o_score,
    input wire                               o_overflow
);

    // A result held by the receiver stays put.
    `GAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_score) && $stable(o_overflow), "result changed while stalled")
    // Back-pressure only comes from a held result.
    `GAS_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a held result")
    // A global score can never beat one match per query symbol.
    `GAS_ASSERT(a_score_max, i_clk, i_rst_n, o_valid, o_score <= gas_pkg::t_score'(gas_pkg::QUERY_MAX), "score above the match bound")

endmodule

bind global_alignment_score_top gas_checker u_gas_checker (.*);

`default_nettype wire
